FILE: rtl/core/sorted_list_store_unit_macros.svh
// Assertion macros for the sorted list store.
`ifndef SORTED_LIST_STORE_UNIT_MACROS_SVH
`define SORTED_LIST_STORE_UNIT_MACROS_SVH

// Checked only outside reset.
`define SLS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SLS_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/slu_pkg.sv
// Package for the sorted list store: sizes, codes and the cell control bundle.
package slu_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_INS  = 2'd1,
    SH_DEL  = 2'd2,
    SH_POP  = 2'd3
  } shift_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_UPD  = 2'd2
  } state_t;

  typedef struct packed {
    logic               cmp;
    shift_t             shift;
    logic [VAL_W-1:0]   operand;
  } slu_ctrl_t;

endpackage

FILE: rtl/core/sorted_list_store_unit.sv
// Top level of the sorted list store: sequencer, count and a chain of cells.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, operation, value      | into block
//  out     | out_valid, out_stall, status,             | out of block
//          | popped_value, entry_count                 |
//
// Each item passes through the steps accept, compare in every cell, then shift and
// load the result register. A new item is accepted only once the sequencer is
// back in idle. Reset clears the count and the sequencer; no clearing pass. A
// stalled result holds the shift step until the result is taken.
module sorted_list_store_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          operation,
  input  logic signed [slu_pkg::VAL_W-1:0]    value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic signed [slu_pkg::VAL_W-1:0]    popped_value,
  output logic [4:0]                          entry_count
);
  import slu_pkg::*;

  state_t                  state, state_next;
  op_t                     op_q;
  logic signed [VAL_W-1:0] val_q;
  logic [CNT_W-1:0]        count, count_next;

  logic [CAPACITY-1:0]     occ;
  logic [CAPACITY-1:0]     lt_vec;
  logic [CAPACITY-1:0]     eq_vec;
  logic signed [VAL_W-1:0] vals [CAPACITY];

  slu_ctrl_t               ctrl;
  shift_t                  shift_sel;
  status_t                 stat_sel;
  logic signed [VAL_W-1:0] pop_sel;
  logic                    hit, full, empty, fire, accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign hit      = |eq_vec;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign fire     = (state == ST_UPD) && (!out_valid || !out_stall);

  always_comb begin
    shift_sel  = SH_HOLD;
    stat_sel   = STAT_OK;
    pop_sel    = '0;
    count_next = count;
    case (op_q)
      OP_INSERT: begin
        if (full) stat_sel = STAT_FULL;
        else begin
          shift_sel  = SH_INS;
          count_next = count + CNT_W'(1);
        end
      end
      OP_SEARCH: stat_sel = hit ? STAT_OK : STAT_MISS;
      OP_DELETE: begin
        if (hit) begin
          shift_sel  = SH_DEL;
          count_next = count - CNT_W'(1);
        end else stat_sel = STAT_MISS;
      end
      OP_POP: begin
        if (empty) stat_sel = STAT_EMPTY;
        else begin
          shift_sel  = SH_POP;
          pop_sel    = vals[0];
          count_next = count - CNT_W'(1);
        end
      end
      default: stat_sel = STAT_OK;
    endcase
  end

  always_comb begin
    state_next   = state;
    ctrl.cmp     = (state == ST_CMP);
    ctrl.shift   = fire ? shift_sel : SH_HOLD;
    ctrl.operand = val_q;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD:  if (fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op_t'(operation);
      val_q <= value;
    end
    if (fire) begin
      status       <= stat_sel;
      popped_value <= pop_sel;
      entry_count  <= 5'(count_next);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count);
    slu_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occ      (occ[i]),
      .prev_lt  ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1]),
      .prev_val ((i == 0) ? val_q : vals[(i == 0) ? 0 : i - 1]),
      .next_val ((i == CAPACITY - 1) ? vals[i] : vals[(i == CAPACITY - 1) ? i : i + 1]),
      .val      (vals[i]),
      .lt       (lt_vec[i]),
      .eq       (eq_vec[i])
    );
  end

`include "sorted_list_store_unit_macros.svh"

  `SLS_CHECK(a_count_bound, count <= CNT_W'(CAPACITY), "count above capacity")
  `SLS_CHECK(a_count_only_on_update, count != $past(count) |-> $past(state == ST_UPD), "count moved outside update")
  `SLS_CHECK(a_full_means_capacity, out_valid && status == STAT_FULL |-> entry_count == 5'(CAPACITY), "full status with spare room")
  `SLS_CHECK_ALWAYS(a_no_accept_busy, state != ST_IDLE |-> in_stall, "input open while busy")

endmodule

FILE: rtl/core/slu_cell.sv
// One compare-and-shift cell of the sorted chain.
module slu_cell (
  input  logic                          clk,
  input  slu_pkg::slu_ctrl_t            ctrl,
  input  logic                          occ,
  input  logic                          prev_lt,
  input  logic signed [slu_pkg::VAL_W-1:0] prev_val,
  input  logic signed [slu_pkg::VAL_W-1:0] next_val,
  output logic signed [slu_pkg::VAL_W-1:0] val,
  output logic                          lt,
  output logic                          eq
);
  import slu_pkg::*;

  logic signed [VAL_W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (ctrl.shift)
      SH_INS: begin
        if (!lt) begin
          if (prev_lt) val_next = $signed(ctrl.operand);
          else         val_next = prev_val;
        end
      end
      SH_DEL: begin
        if (!lt) val_next = next_val;
      end
      SH_POP: val_next = next_val;
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      lt <= occ && (val < $signed(ctrl.operand));
      eq <= occ && (val == $signed(ctrl.operand));
    end
    val <= val_next;
  end

endmodule
